/* rtl/n3c_pkg.sv */
// Shared types and constants for the normalized 3x3 convolution block.
package n3c_pkg;

   localparam int MaxWidth = 1024;
   localparam int PixW     = 24;
   localparam int CoefW    = 16;
   localparam int AccW     = 36;
   localparam int DivW     = 36;

   typedef enum logic [2:0] {
      REG_COLOR_MODE = 3'd0,
      REG_WIDTH      = 3'd1,
      REG_HEIGHT     = 3'd2,
      REG_COEF_LOW   = 3'd3,
      REG_COEF_MID   = 3'd4,
      REG_COEF_HIGH  = 3'd5
   } reg_index_type;

   // one result to be computed: position, 3x3 window, last flag
   typedef struct packed {
      logic [9:0]           row;
      logic [9:0]           col;
      logic [8:0][PixW-1:0] win;   // index 3*a+b, a = row offset, b = col offset
      logic                 last;
   } job_type;

   typedef struct packed {
      logic [9:0] row;
      logic [9:0] col;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } result_type;

endpackage

/* rtl/n3c_if.sv */
// Valid/ready stream interfaces for pixels, results and register writes.
interface n3c_pix_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

interface n3c_res_if;
   logic       valid;
   logic       ready;
   logic [9:0] out_row;
   logic [9:0] out_col;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic       run_last;
   modport source (output valid, out_row, out_col, out_red, out_green, out_blue, run_last,
                   input ready);
   modport sink   (input valid, out_row, out_col, out_red, out_green, out_blue, run_last,
                   output ready);
endinterface

interface n3c_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/n3c_ram.sv */
// Generic single-port-write, one-read synchronous RAM with registered read.
module n3c_ram #(
   parameter int Width = 24,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

/* rtl/n3c_divider.sv */
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
module n3c_divider
   import n3c_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [AccW-1:0]  dividend,
   input  logic signed [19:0]      divisor,
   output logic                    done,
   output logic signed [AccW-1:0]  quotient
);
   localparam int CntW = $clog2(DivW + 1);

   logic [DivW-1:0] num_ff, num_in;
   logic [DivW:0]   rem_ff, rem_in;
   logic [19:0]     den_ff, den_in;
   logic            neg_ff, neg_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [DivW:0]   trial;
   logic [DivW:0]   shifted;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[DivW-1:0], num_ff[DivW-1]};
      trial   = shifted - {{(DivW-19){1'b0}}, den_ff};
      if (start) begin
         num_in  = dividend[AccW-1] ? DivW'(-dividend) : DivW'(dividend);
         den_in  = divisor[19] ? 20'(-divisor) : divisor;
         neg_in  = dividend[AccW-1] ^ divisor[19];
         rem_in  = '0;
         cnt_in  = CntW'(DivW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DivW]) begin
            rem_in = trial;
            num_in = {num_ff[DivW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            num_in = {num_ff[DivW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? AccW'(-$signed({1'b0, num_ff})) : $signed(num_ff);
endmodule

/* rtl/n3c_filter.sv */
// Filter unit: nine-tap multiply-accumulate per channel, normalize, clamp.
module n3c_filter
   import n3c_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  job_type                 job,
   input  logic [8:0][CoefW-1:0]   coef,
   input  logic                    color_mode,
   output logic                    done,
   output result_type              result
);
   typedef enum logic [1:0] {S_IDLE, S_MAC, S_DIV, S_DONE} state_type;

   state_type         state_ff;
   job_type           job_ff;
   logic [3:0]        tap_ff;
   logic [1:0]        ch_ff;
   logic signed [AccW-1:0] acc_ff [3];
   logic signed [24:0] prod_ff;
   logic              prod_vld_ff;
   logic [1:0]        prod_ch_ff;
   logic [7:0]        q_ff [3];
   logic signed [19:0] weight_ff;
   logic              done_ff;

   logic [3:0]        kidx;
   logic [7:0]        px;
   logic              div_start, div_done;
   logic signed [AccW-1:0] div_q;
   logic signed [AccW-1:0] div_a;
   logic signed [19:0] weight;
   logic [1:0]        nch;

   // reflected mask: tap 3a+b uses coefficient 8-(3a+b)
   assign kidx = 4'd8 - tap_ff;
   assign px   = job_ff.win[tap_ff][8*ch_ff +: 8];
   assign nch  = color_mode ? 2'd3 : 2'd1;

   always_comb begin
      weight = '0;
      for (int i = 0; i < 9; i++) weight = weight + 20'($signed(coef[i]));
   end

   assign div_start = (state_ff == S_MAC) && !prod_vld_ff && tap_ff == 4'd9;
   assign div_a     = acc_ff[ch_ff];

   n3c_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (weight_ff == 20'sd0 ? 20'sd256 : weight_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         done_ff     <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         done_ff     <= (state_ff == S_DIV) && div_done && (ch_ff + 2'd1 == nch);
         prod_vld_ff <= (state_ff == S_MAC) && (tap_ff != 4'd9);
         if (prod_vld_ff) acc_ff[prod_ch_ff] <= acc_ff[prod_ch_ff] + AccW'(prod_ff);
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  job_ff    <= job;
                  weight_ff <= weight;
                  tap_ff    <= '0;
                  ch_ff     <= '0;
                  acc_ff[0] <= '0;
                  acc_ff[1] <= '0;
                  acc_ff[2] <= '0;
                  q_ff[1]   <= '0;
                  q_ff[2]   <= '0;
                  state_ff  <= S_MAC;
               end
            end
            S_MAC: begin
               if (tap_ff != 4'd9) begin
                  prod_ff     <= $signed({1'b0, px}) * $signed(coef[kidx]);
                  prod_ch_ff  <= ch_ff;
                  tap_ff      <= tap_ff + 1'b1;
               end else if (!prod_vld_ff) begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  if (div_q < 0) q_ff[ch_ff] <= 8'd0;
                  else if (div_q > 255) q_ff[ch_ff] <= 8'd255;
                  else q_ff[ch_ff] <= div_q[7:0];
                  if (ch_ff + 2'd1 == nch) begin
                     state_ff <= S_DONE;
                  end else begin
                     ch_ff    <= ch_ff + 1'b1;
                     tap_ff   <= '0;
                     state_ff <= S_MAC;
                  end
               end
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done         = done_ff;
   assign result.row   = job_ff.row;
   assign result.col   = job_ff.col;
   assign result.red   = q_ff[0];
   assign result.green = q_ff[1];
   assign result.blue  = q_ff[2];
   assign result.last  = job_ff.last;
endmodule

/* rtl/normalized_3x3_convolution.sv */
// Top level of the normalized 3x3 convolution block.
//
// Pixels enter one item at a time in raster order; each channel (only red in
// gray mode) is filtered with a 3x3 signed Q8.8 kernel (reflected), divided
// by the kernel weight (or by 256 when the weight is zero), truncated toward
// zero and clamped to 0..255. Edge neighbours repeat the nearest edge pixel.
// A pixel releases up to four results (the pixel up-left of it, plus edge
// results on the last column and last row); run_last marks the final one of
// the group. The two previous rows sit in two line RAMs with registered
// reads: an accepted pixel reads both at the accepting edge, then writes them
// back in S_PLAN, after S_READ. Each result runs through one shared multiplier
// (nine taps per channel) and one bit-serial divider, channel after channel,
// and unused candidate positions are stepped over in S_OUT ahead of it.
// Finished results go to a single output register, so a stalled receiver
// only holds the block once the next result is ready to leave. Writing
// image_width or image_height restarts the frame at (0,0). Coefficient
// registers are index 3 (taps 0..3), 4 (taps 4..7) and 5 (tap 8).
module normalized_3x3_convolution
   import n3c_pkg::*;
(
   input  logic clock,
   input  logic reset,
   n3c_pix_if.sink   req,
   n3c_res_if.source rsp,
   n3c_csr_if.sink   csr
);
   localparam int AddrW = $clog2(MaxWidth);

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_PLAN, S_EMIT, S_WAIT, S_OUT, S_HAND
   } state_type;

   // configuration
   logic        color_mode_ff;
   logic [10:0] width_ff, height_ff;
   logic [63:0] coef_low_ff, coef_mid_ff;
   logic [15:0] coef_high_ff;
   logic [8:0][CoefW-1:0] coef;

   // position and window
   logic [9:0]  row_ff, col_ff;
   logic [5:0][PixW-1:0] wcol_ff;     // slot cs*3+rs, cs 0..1
   logic [PixW-1:0] pix_ff;
   logic [9:0]  r_ff, c_ff;
   logic [3:0]  plan_ff;              // bit k: emit candidate k
   logic [1:0]  cand_ff;
   state_type   state_ff;
   result_type  res_ff;
   logic        rsp_valid_ff;

   logic [10:0] eff_w, eff_h;
   logic [9:0]  r_cur, c_cur;
   logic [PixW-1:0] up_rd, lo_rd;
   logic        acc_pix;
   logic [AddrW-1:0] addr;
   logic        filt_start, filt_done;
   job_type     job;
   result_type  filt_res;
   logic [9:0]  tr, tc;
   logic [3:0]  plan_next;
   logic        out_load;

   assign coef = {coef_high_ff, coef_mid_ff, coef_low_ff};

   always_comb begin
      eff_w = (width_ff == 11'd0) ? 11'd1 :
              (width_ff > 11'(MaxWidth)) ? 11'(MaxWidth) : width_ff;
      eff_h = (height_ff == 11'd0) ? 11'd1 :
              (height_ff > 11'd1024) ? 11'd1024 : height_ff;
      if ({1'b0, col_ff} >= eff_w || {1'b0, row_ff} >= eff_h) begin
         r_cur = '0;
         c_cur = '0;
      end else begin
         r_cur = row_ff;
         c_cur = col_ff;
      end
   end

   assign acc_pix   = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE) && !csr.valid;
   assign csr.ready = (state_ff == S_IDLE);
   assign addr      = (state_ff == S_IDLE) ? AddrW'(c_cur) : AddrW'(c_ff);

   // output register takes the filter result once it is free or being emptied
   assign out_load  = (state_ff == S_HAND) && (!rsp_valid_ff || rsp.ready);

   n3c_ram #(.Width(PixW), .Depth(MaxWidth)) u_upper (
      .clock   (clock),
      .wr_en   (state_ff == S_PLAN),
      .wr_addr (addr),
      .wr_data (lo_rd),
      .rd_en   (acc_pix),
      .rd_addr (addr),
      .rd_data (up_rd)
   );

   n3c_ram #(.Width(PixW), .Depth(MaxWidth)) u_lower (
      .clock   (clock),
      .wr_en   (state_ff == S_PLAN),
      .wr_addr (addr),
      .wr_data (pix_ff),
      .rd_en   (acc_pix),
      .rd_addr (addr),
      .rd_data (lo_rd)
   );

   // candidate target of current emit
   always_comb begin
      tr = ((cand_ff == 2'd2) || (cand_ff == 2'd3)) ? r_ff : r_ff - 1'b1;
      tc = ((cand_ff == 2'd1) || (cand_ff == 2'd3)) ? c_ff : c_ff - 1'b1;
   end

   // window gather with edge clamping; column slot 2 = current column
   logic [8:0][PixW-1:0] win_sel;
   logic [2:0][2:0][PixW-1:0] full_ff;   // [cs][rs]
   always_comb begin
      logic signed [11:0] rr, cc;
      logic [1:0] rs, cs;
      win_sel = '0;
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            rr = $signed({2'b0, tr}) + 12'(a) - 12'sd1;
            if (rr < 0) rr = 0;
            if (rr > $signed({1'b0, eff_h}) - 12'sd1) rr = $signed({1'b0, eff_h}) - 12'sd1;
            rr = rr - ($signed({2'b0, r_ff}) - 12'sd2);
            cc = $signed({2'b0, tc}) + 12'(b) - 12'sd1;
            if (cc < 0) cc = 0;
            if (cc > $signed({1'b0, eff_w}) - 12'sd1) cc = $signed({1'b0, eff_w}) - 12'sd1;
            cc = cc - ($signed({2'b0, c_ff}) - 12'sd2);
            rs = (rr < 0) ? 2'd0 : (rr > 2) ? 2'd2 : rr[1:0];
            cs = (cc < 0) ? 2'd0 : (cc > 2) ? 2'd2 : cc[1:0];
            win_sel[3*a+b] = full_ff[cs][rs];
         end
      end
   end

   assign job.row  = tr;
   assign job.col  = tc;
   assign job.win  = win_sel;
   assign job.last = ((plan_ff >> (3'(cand_ff) + 3'd1)) == 4'd0);
   assign filt_start = (state_ff == S_EMIT);

   n3c_filter u_filter (
      .clock      (clock),
      .reset      (reset),
      .start      (filt_start),
      .job        (job),
      .coef       (coef),
      .color_mode (color_mode_ff),
      .done       (filt_done),
      .result     (filt_res)
   );

   always_comb begin
      plan_next    = '0;
      plan_next[0] = (r_ff >= 10'd1) && (c_ff >= 10'd1);
      plan_next[1] = (r_ff >= 10'd1) && ({1'b0, c_ff} == eff_w - 11'd1);
      plan_next[2] = ({1'b0, r_ff} == eff_h - 11'd1) && (c_ff >= 10'd1);
      plan_next[3] = ({1'b0, r_ff} == eff_h - 11'd1) && ({1'b0, c_ff} == eff_w - 11'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         color_mode_ff <= 1'b1;
         width_ff      <= 11'd1024;
         height_ff     <= 11'd1024;
         coef_low_ff   <= '0;
         coef_mid_ff   <= '0;
         coef_high_ff  <= 16'd256;
         row_ff        <= '0;
         col_ff        <= '0;
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_COLOR_MODE: color_mode_ff <= csr.data[0];
               REG_WIDTH: begin
                  width_ff <= csr.data[10:0];
                  row_ff   <= '0;
                  col_ff   <= '0;
               end
               REG_HEIGHT: begin
                  height_ff <= csr.data[10:0];
                  row_ff    <= '0;
                  col_ff    <= '0;
               end
               REG_COEF_LOW:  coef_low_ff  <= csr.data;
               REG_COEF_MID:  coef_mid_ff  <= csr.data;
               REG_COEF_HIGH: coef_high_ff <= csr.data[15:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (acc_pix) begin
                  pix_ff   <= {req.blue, req.green, req.red};
                  r_ff     <= r_cur;
                  c_ff     <= c_cur;
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_PLAN;
            S_PLAN: begin
               full_ff[0] <= wcol_ff[2:0];
               full_ff[1] <= wcol_ff[5:3];
               full_ff[2] <= {pix_ff, lo_rd, up_rd};
               wcol_ff[2:0] <= wcol_ff[5:3];
               wcol_ff[5:3] <= {pix_ff, lo_rd, up_rd};
               plan_ff  <= plan_next;
               cand_ff  <= '0;
               if ({1'b0, c_ff} + 11'd1 >= eff_w) begin
                  col_ff <= '0;
                  row_ff <= ({1'b0, r_ff} + 11'd1 >= eff_h) ? 10'd0 : r_ff + 1'b1;
               end else begin
                  col_ff <= c_ff + 1'b1;
                  row_ff <= r_ff;
               end
               state_ff <= (plan_next == 4'd0) ? S_IDLE : S_OUT;
            end
            S_OUT: begin
               // advance to next planned candidate
               if (plan_ff[cand_ff]) state_ff <= S_EMIT;
               else cand_ff <= cand_ff + 1'b1;
            end
            S_EMIT: state_ff <= S_WAIT;
            S_WAIT: begin
               if (filt_done) state_ff <= S_HAND;
            end
            S_HAND: begin
               // filter holds its result until the next start
               if (out_load) begin
                  res_ff <= filt_res;
                  if (filt_res.last) state_ff <= S_IDLE;
                  else begin
                     cand_ff  <= cand_ff + 1'b1;
                     state_ff <= S_OUT;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // result register valid flag
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (out_load) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_row   = res_ff.row;
   assign rsp.out_col   = res_ff.col;
   assign rsp.out_red   = res_ff.red;
   assign rsp.out_green = res_ff.green;
   assign rsp.out_blue  = res_ff.blue;
   assign rsp.run_last  = res_ff.last;

`ifndef SYNTHESIS
   a_no_pix_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !acc_pix) else $error("pixel taken while busy");
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("result dropped while stalled");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      filt_done |-> (state_ff == S_WAIT)) else $error("filter done unexpected");
`endif
endmodule

/* bench/n3c_checker.sv */
// Checker for the 3x3 convolution block: predicts results and compares them.
`timescale 1ns / 1ps
module n3c_checker
   import n3c_pkg::*;
(
   input  logic clock,
   input  logic reset,
   n3c_pix_if   pix,
   n3c_res_if   res,
   n3c_csr_if   cfg,
   output int   fail_count,
   output int   pending
);

   localparam int MaxW = 1024;
   localparam int MaxH = 1024;

   logic        mode_rgb;
   logic [10:0] width_reg;
   logic [10:0] height_reg;
   logic [63:0] taps_low;
   logic [63:0] taps_mid;
   logic [15:0] tap_high;

   logic [23:0] upper_row [MaxW];
   logic [23:0] lower_row [MaxW];
   logic [23:0] win_cols [6];
   int          col_pos;
   int          row_pos;

   result_type  filtered_q[$];

   assign pending = filtered_q.size();

   function automatic int tap(int n);
      logic [15:0] t;
      if (n < 4)      t = taps_low[16*n +: 16];
      else if (n < 8) t = taps_mid[16*(n-4) +: 16];
      else            t = tap_high;
      return int'($signed(t));
   endfunction

   function automatic int clip(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // win[cs][rs]: pixel at column C-2+cs, row R-2+rs
   function automatic result_type filter_at(logic [23:0] win [3][3], int r, int c,
                                            int tr, int tc, int w, int h);
      result_type o;
      int         weight;
      int         rs;
      int         cs;
      int         k;
      longint     acc [3];
      longint     q;
      weight = 0;
      for (int n = 0; n < 9; n++) weight += tap(n);
      for (int ch = 0; ch < 3; ch++) acc[ch] = 0;
      for (int a = 0; a < 3; a++) begin
         rs = clip(clip(tr + a - 1, 0, h - 1) - (r - 2), 0, 2);
         for (int b = 0; b < 3; b++) begin
            cs = clip(clip(tc + b - 1, 0, w - 1) - (c - 2), 0, 2);
            k  = tap(3 * (2 - a) + (2 - b));   // reflected kernel
            for (int ch = 0; ch < 3; ch++)
               acc[ch] += longint'(win[cs][rs][8*ch +: 8]) * k;
         end
      end
      o.row = tr[9:0];
      o.col = tc[9:0];
      o.last = 1'b0;
      for (int ch = 0; ch < 3; ch++) begin
         q = 0;
         if (ch == 0 || mode_rgb) begin
            q = (weight != 0) ? acc[ch] / weight : acc[ch] / 256;
            q = q < 0 ? 0 : (q > 255 ? 255 : q);
         end
         if (ch == 0)      o.red   = q[7:0];
         else if (ch == 1) o.green = q[7:0];
         else              o.blue  = q[7:0];
      end
      return o;
   endfunction

   task automatic predict_pixel(logic [23:0] px);
      logic [23:0] win [3][3];
      int          w;
      int          h;
      int          r;
      int          c;
      int          ci;
      int          n;
      w = clip(int'(width_reg), 1, MaxW);
      h = clip(int'(height_reg), 1, MaxH);
      r = row_pos;
      c = col_pos;
      n = 0;
      if (c >= w || r >= h) begin
         c = 0;
         r = 0;
      end
      ci = c % MaxW;
      for (int i = 0; i < 3; i++) begin
         win[0][i] = win_cols[i];
         win[1][i] = win_cols[3+i];
      end
      win[2][0] = upper_row[ci];
      win[2][1] = lower_row[ci];
      win[2][2] = px;
      if (r >= 1 && c >= 1) begin
         filtered_q = {filtered_q, filter_at(win, r, c, r - 1, c - 1, w, h)}; n++;
      end
      if (r >= 1 && c == w - 1) begin
         filtered_q = {filtered_q, filter_at(win, r, c, r - 1, c, w, h)}; n++;
      end
      if (r == h - 1 && c >= 1) begin
         filtered_q = {filtered_q, filter_at(win, r, c, r, c - 1, w, h)}; n++;
      end
      if (r == h - 1 && c == w - 1) begin
         filtered_q = {filtered_q, filter_at(win, r, c, r, c, w, h)}; n++;
      end
      if (n > 0) filtered_q[filtered_q.size()-1].last = 1'b1;
      for (int i = 0; i < 3; i++) begin
         win_cols[i]   = win[1][i];
         win_cols[3+i] = win[2][i];
      end
      upper_row[ci] = win[2][1];
      lower_row[ci] = px;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   task automatic check_result();
      result_type got;
      result_type want;
      got.row   = res.out_row;
      got.col   = res.out_col;
      got.red   = res.out_red;
      got.green = res.out_green;
      got.blue  = res.out_blue;
      got.last  = res.run_last;
      if (filtered_q.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display({"unexpected result: expected none, ",
                      "got row %0d col %0d rgb %0d %0d %0d last %0b"},
                     got.row, got.col, got.red, got.green, got.blue, got.last);
      end else begin
         want = filtered_q.pop_front();
         if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
               $display({"result mismatch: expected row %0d col %0d rgb %0d %0d %0d ",
                         "last %0b, got row %0d col %0d rgb %0d %0d %0d last %0b"},
                        want.row, want.col, want.red, want.green, want.blue, want.last,
                        got.row, got.col, got.red, got.green, got.blue, got.last);
         end
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         mode_rgb   = 1'b1;
         width_reg  = 11'd1024;
         height_reg = 11'd1024;
         taps_low   = '0;
         taps_mid   = '0;
         tap_high   = 16'd256;
         col_pos    = 0;
         row_pos    = 0;
         for (int i = 0; i < MaxW; i++) begin
            upper_row[i] = '0;
            lower_row[i] = '0;
         end
         for (int i = 0; i < 6; i++) win_cols[i] = '0;
         filtered_q.delete();
      end else begin
         // older items first: a result never belongs to a pixel of this same edge
         if (res.valid && res.ready) check_result();
         if (cfg.valid && cfg.ready) begin
            case (cfg.index)
               REG_COLOR_MODE: mode_rgb = cfg.data[0];
               REG_WIDTH: begin
                  width_reg = cfg.data[10:0]; col_pos = 0; row_pos = 0;
               end
               REG_HEIGHT: begin
                  height_reg = cfg.data[10:0]; col_pos = 0; row_pos = 0;
               end
               REG_COEF_LOW:  taps_low = cfg.data;
               REG_COEF_MID:  taps_mid = cfg.data;
               REG_COEF_HIGH: tap_high = cfg.data[15:0];
               default: ;
            endcase
         end
         if (pix.valid && pix.ready) predict_pixel({pix.blue, pix.green, pix.red});
      end
   end

endmodule

/* bench/tb_normalized_3x3_convolution.sv */
// Testbench top: drives pixels and register writes, gives the verdict.
`timescale 1ns / 1ps
module tb_normalized_3x3_convolution;
   import n3c_pkg::*;

   localparam logic [2:0] REG_SPARE = 3'd6;   // no register behind this index
   localparam int TargetItems = 170;
   localparam int CycleLimit  = 1000000;
   localparam int SettleWait  = 40;           // a pixel with no result still passes through S_READ and S_PLAN
   localparam int LongHold    = 1500;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   cycles;
   int   items_sent;
   bit   calm;        // no idling on either side in this phase
   bit   hold_armed;  // receiver stalls for a long stretch on its next item

   n3c_pix_if req_ch ();
   n3c_res_if rsp_ch ();
   n3c_csr_if csr_ch ();

   normalized_3x3_convolution uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   n3c_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .pix        (req_ch),
      .res        (rsp_ch),
      .cfg        (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run-away guard
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Receiver: random stall per item, one long hold on request.
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 18);
         if (hold_armed) begin
            gap = LongHold;
            hold_armed = 1'b0;
         end
         if (gap > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 18);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.red   = r;
      req_ch.green = g;
      req_ch.blue  = b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic write_reg(logic [2:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Block must be idle before any register write.
   task automatic drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SettleWait) @(posedge clock);
   endtask

   task automatic configure(bit rgb, int w, int h, logic [63:0] lo, logic [63:0] mid,
                            logic [15:0] hi);
      drain();
      write_reg(REG_COLOR_MODE, 64'(rgb));
      write_reg(REG_COEF_LOW, lo);
      write_reg(REG_COEF_MID, mid);
      write_reg(REG_COEF_HIGH, 64'(hi));
      write_reg(REG_WIDTH, 64'(w));
      write_reg(REG_HEIGHT, 64'(h));
   endtask

   function automatic logic [15:0] rand_tap();
      case ($urandom_range(0, 4))
         0: return 16'($signed($urandom_range(0, 1024)) - 512);
         1: return 16'($urandom);
         2: return 16'd0;
         3: return 16'($urandom_range(0, 512));
         default: return 16'd256;
      endcase
   endfunction

   task automatic random_pixels(int n);
      for (int i = 0; i < n; i++)
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   initial begin
      int          w;
      int          h;
      int          n;
      logic [63:0] lo;
      logic [63:0] mid;
      bit          first_random;
      reset        = 1'b1;
      calm         = 1'b0;
      hold_armed   = 1'b0;
      items_sent   = 0;
      req_ch.valid = 1'b0;
      req_ch.red   = '0;
      req_ch.green = '0;
      req_ch.blue  = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_COLOR_MODE;
      csr_ch.data  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Single pixel frame, gray, identity kernel (center tap is index 4).
      configure(1'b0, 1, 1, 64'd0, 64'd256, 16'd0);
      write_reg(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);   // ignored
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd128, 8'd1, 8'd254);

      // Width/height 0 act as 1; all taps at the largest positive value.
      configure(1'b1, 0, 0, {4{16'h7FFF}}, {4{16'h7FFF}}, 16'h7FFF);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd170);

      // Oversized width clamps to the maximum; zero-weight Laplacian.
      configure(1'b1, 2047, 1, {4{16'hFF00}}, {{3{16'hFF00}}, 16'h0800}, 16'hFF00);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);

      // Oversized height; all taps at the most negative value.
      configure(1'b0, 2, 2047, {4{16'h8000}}, {4{16'h8000}}, 16'h8000);
      random_pixels(6);

      // Full small frame, random kernel, wraps into a second frame.
      configure(1'b1, 3, 3, {rand_tap(), rand_tap(), rand_tap(), rand_tap()},
                {rand_tap(), rand_tap(), rand_tap(), rand_tap()}, rand_tap());
      random_pixels(11);

      // Random phases: small frames, half of them whole frames, some cut short, some running into the next frame.
      first_random = 1'b1;
      while (items_sent < TargetItems) begin
         case ($urandom_range(0, 9))
            0:       w = $urandom_range(7, 12);
            1:       w = 0;
            default: w = $urandom_range(1, 6);
         endcase
         h   = $urandom_range(1, 5);
         lo  = {rand_tap(), rand_tap(), rand_tap(), rand_tap()};
         mid = {rand_tap(), rand_tap(), rand_tap(), rand_tap()};
         configure(1'($urandom_range(0, 1)), w, h, lo, mid, rand_tap());
         calm = ($urandom_range(0, 3) == 0);
         n = (w < 1 ? 1 : w) * h;
         if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
         else if ($urandom_range(0, 2) == 0) n += $urandom_range(1, n);
         if (first_random) begin
            // sender keeps offering while the receiver sits still
            calm = 1'b1;
            hold_armed = 1'b1;
            first_random = 1'b0;
            if (n < 12) n = 12;
         end
         random_pixels(n);
      end

      drain();
      calm = 1'b0;
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
